@@ rtl/core/smeu_pkg.sv @@
// Shared constants, opcode and code types for the stack machine execute unit.
package smeu_pkg;

  localparam int unsigned SmeuStackDepth = 1024;
  localparam int unsigned SmeuCodeDepth  = 4096;

  localparam int unsigned DataW = 32;
  localparam int unsigned WideW = 34;
  localparam int unsigned LenW  = 13;
  localparam int unsigned TgtW  = 12;
  localparam int unsigned CmdW  = 5;

  localparam int PrintLow  = 32;
  localparam int PrintHigh = 126;

  typedef enum logic [CmdW-1:0] {
    OP_AMEM  = 5'd0,  OP_DMEM  = 5'd1,  OP_CRCT  = 5'd2,  OP_CRVL  = 5'd3,
    OP_ARMZ  = 5'd4,  OP_SOMA  = 5'd5,  OP_SUBT  = 5'd6,  OP_MULT  = 5'd7,
    OP_DIVI  = 5'd8,  OP_INVR  = 5'd9,  OP_CONJ  = 5'd10, OP_DISJ  = 5'd11,
    OP_CMME  = 5'd12, OP_CMMA  = 5'd13, OP_CMEQ  = 5'd14, OP_CDIF  = 5'd15,
    OP_CMMEQ = 5'd16, OP_CMMAQ = 5'd17, OP_DSVS  = 5'd18, OP_DSVF  = 5'd19,
    OP_CHPR  = 5'd20, OP_CHPD  = 5'd21, OP_CHLE  = 5'd22, OP_PARA  = 5'd23,
    OP_CHAM  = 5'd24, OP_RETOR = 5'd25, OP_CRVI  = 5'd26, OP_ARMI  = 5'd27,
    OP_TROCA = 5'd28
  } op_e;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_CHAR = 2'd1,
    PK_NUM  = 2'd2
  } print_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_DIV_ZERO    = 2'd1,
    ERR_UNKNOWN_OP  = 2'd2,
    ERR_STACK_RANGE = 2'd3
  } err_e;

  typedef logic signed [WideW-1:0] wide_t;

  // Sign-extends a stack cell to the wide signed width used for range checks.
  function automatic wide_t sx32(input logic [DataW-1:0] v);
    return wide_t'($signed(v));
  endfunction

endpackage

@@ rtl/core/smeu_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module smeu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/smeu_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smeu_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [smeu_pkg::DataW-1:0] dividend_i,
  input  logic [smeu_pkg::DataW-1:0] divisor_i,
  output logic                     done_o,
  output logic [smeu_pkg::DataW-1:0] quotient_o
);
  import smeu_pkg::*;

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d, quo_q, quo_d, mb_q, mb_d;
  logic            neg_q, neg_d;
  logic [DataW:0]  shifted, diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    mb_d    = mb_q;
    neg_d   = neg_q;
    shifted = {rem_q, quo_q[DataW-1]};
    diff    = shifted - {1'b0, mb_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DataW);
      rem_d  = '0;
      quo_d  = dividend_i[DataW-1] ? -dividend_i : dividend_i;
      mb_d   = divisor_i[DataW-1] ? -divisor_i : divisor_i;
      neg_d  = dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -quo_q : quo_q;

endmodule

@@ rtl/core/stack_machine_execute_unit.sv @@
// Top level of the stack machine execute unit: sequencer, pointers, divider and stack RAM.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | cmd_i, argument_i, branch_target_i,
//           |           |                          | read_value_i
//   out     | output    | out_valid_o / out_ready_i| next_pc_o, print_kind_o, print_value_o,
//           |           |                          | halted_o, error_code_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (program length)
//
// Each instruction goes from its input transfer to its result through decode, two
// stack RAM read steps and one execute step, set by the single read port of the RAM.
// The next transfer is taken in the idle state. CHAM and TROCA write two cells and
// pass through a second write state before the next transfer; DIVI runs the
// bit-serial divider and then a second execute step. After reset a clearing pass
// writes zero into every stack cell, during which no instruction is taken; program
// length writes are always taken. A stalled result stays in the output register while
// the next instruction is already taken and worked on up to its execute cycle.
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = smeu_pkg::SmeuStackDepth,
  parameter int unsigned CODE_DEPTH  = smeu_pkg::SmeuCodeDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [smeu_pkg::LenW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [smeu_pkg::CmdW-1:0]   cmd_i,
  input  logic [smeu_pkg::DataW-1:0]  argument_i,
  input  logic [smeu_pkg::TgtW-1:0]   branch_target_i,
  input  logic [smeu_pkg::DataW-1:0]  read_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [smeu_pkg::LenW-1:0]   next_pc_o,
  output logic [1:0]                  print_kind_o,
  output logic [smeu_pkg::DataW-1:0]  print_value_o,
  output logic                        halted_o,
  output logic [1:0]                  error_code_o
);
  import smeu_pkg::*;

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PcW = ($clog2(CODE_DEPTH + 1) > LenW) ? $clog2(CODE_DEPTH + 1) : LenW;

  // Sequencer states; every instruction passes through S_IDLE, S_DEC, S_RD1, S_RD2 and S_EXE.
  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_DEC  = 8'b0000_0100,
    S_RD1  = 8'b0000_1000,
    S_RD2  = 8'b0001_0000,
    S_EXE  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_WR2  = 8'b1000_0000
  } state_e;

  localparam wide_t DepthW = wide_t'(STACK_DEPTH);
  localparam wide_t CodeW  = wide_t'(CODE_DEPTH);

  state_e state_q, state_d;

  // Architectural state.
  logic [SW-1:0]   sp_q, fp_q;
  logic [PcW-1:0]  pc_q;
  logic            stopped_q;
  err_e            fault_q;
  logic [LenW-1:0] plen_q;

  // Captured instruction and operands.
  logic [CmdW-1:0]  cmd_q;
  logic [DataW-1:0] arg_q, rdv_q, a_q, b_q;
  logic [TgtW-1:0]  tgt_q;
  wide_t            fa_q, adj_q, fa_d, adj_d;
  logic             divd_q;
  logic [AW-1:0]    clr_q;
  logic [AW-1:0]    w2_addr_q;
  logic [DataW-1:0] w2_data_q;

  // Output register.
  logic             out_valid_q;
  logic [LenW-1:0]  opc_q;
  print_kind_e      okind_q;
  logic [DataW-1:0] opval_q;
  logic             ohalt_q;
  err_e             oerr_q;

  // Stack RAM ports.
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  // Divider.
  logic             div_start, div_done;
  logic [DataW-1:0] div_quo;

  logic [PcW-1:0]  len;
  logic [SW-1:0]   sp_m1, sp_m2, fp_m1, fp_m2;
  logic            accept, ex_go;

  // Execute-cycle results.
  err_e             ex_err;
  logic             halt_resp, need_div;
  logic [SW-1:0]    nsp, nfp;
  logic [PcW-1:0]   npc;
  print_kind_e      kind;
  logic [DataW-1:0] pval, alu, prod;
  logic             w1_en, w2_en;
  logic [AW-1:0]    w1_addr, w2_addr;
  logic [DataW-1:0] w1_data, w2_data;
  wide_t            a_w, b_w;

  assign len = (PcW'(plen_q) > PcW'(CODE_DEPTH)) ? PcW'(CODE_DEPTH) : PcW'(plen_q);

  assign sp_m1 = sp_q - SW'(1);
  assign sp_m2 = sp_q - SW'(2);
  assign fp_m1 = fp_q - SW'(1);
  assign fp_m2 = fp_q - SW'(2);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  // Frame-relative address and moved stack top are formed in the decode cycle.
  assign fa_d  = wide_t'(WideW'(fp_q)) + sx32(arg_q);
  assign adj_d = (op_e'(cmd_q) == OP_AMEM) ? wide_t'(WideW'(sp_q)) + sx32(arg_q)
                                           : wide_t'(WideW'(sp_q)) - sx32(arg_q);

  // First read in the decode cycle, second read in the cycle after it. Addresses that
  // are out of range occur only where the data is unused or the path ends in an error.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = sp_m1[AW-1:0];
    if (state_q == S_DEC) begin
      ram_re = 1'b1;
      unique case (op_e'(cmd_q))
        OP_CRVL: ram_raddr = fa_d[AW-1:0];
        OP_SOMA, OP_SUBT, OP_MULT, OP_DIVI, OP_CONJ, OP_DISJ, OP_CMME, OP_CMMA,
        OP_CMEQ, OP_CDIF, OP_CMMEQ, OP_CMMAQ, OP_TROCA: ram_raddr = sp_m2[AW-1:0];
        OP_RETOR: ram_raddr = fp_m1[AW-1:0];
        default:  ram_raddr = sp_m1[AW-1:0];
      endcase
    end else if (state_q == S_RD1) begin
      ram_re = 1'b1;
      unique case (op_e'(cmd_q))
        OP_ARMI:  ram_raddr = sp_m2[AW-1:0];
        OP_RETOR: ram_raddr = fp_m2[AW-1:0];
        OP_CRVI:  ram_raddr = ram_rdata[AW-1:0];
        default:  ram_raddr = sp_m1[AW-1:0];
      endcase
    end
  end

  assign prod = a_q * b_q;
  assign a_w  = sx32(a_q);
  assign b_w  = sx32(b_q);

  // Binary operation on the two top cells; a is the lower cell.
  always_comb begin
    unique case (op_e'(cmd_q))
      OP_SOMA:  alu = a_q + b_q;
      OP_SUBT:  alu = a_q - b_q;
      OP_MULT:  alu = prod;
      OP_DIVI:  alu = div_quo;
      OP_CONJ:  alu = DataW'((a_q != '0) && (b_q != '0));
      OP_DISJ:  alu = DataW'((a_q != '0) || (b_q != '0));
      OP_CMME:  alu = DataW'(a_w < b_w);
      OP_CMMA:  alu = DataW'(a_w > b_w);
      OP_CMEQ:  alu = DataW'(a_q == b_q);
      OP_CDIF:  alu = DataW'(a_q != b_q);
      OP_CMMEQ: alu = DataW'(a_w <= b_w);
      default:  alu = DataW'(a_w >= b_w);
    endcase
  end

  // Execute cycle: range checks, new pointers, cell writes and print data.
  always_comb begin
    ex_err    = ERR_NONE;
    need_div  = 1'b0;
    nsp       = sp_q;
    nfp       = fp_q;
    npc       = pc_q + PcW'(1);
    kind      = PK_NONE;
    pval      = '0;
    w1_en     = 1'b0;
    w1_addr   = sp_q[AW-1:0];
    w1_data   = '0;
    w2_en     = 1'b0;
    w2_addr   = sp_q[AW-1:0];
    w2_data   = '0;
    halt_resp = stopped_q || (pc_q >= len);
    if (!halt_resp) begin
      unique case (op_e'(cmd_q))
        OP_AMEM, OP_DMEM: begin
          if (adj_q < 0 || adj_q > DepthW) ex_err = ERR_STACK_RANGE;
          else nsp = adj_q[SW-1:0];
        end
        OP_CRCT, OP_CHLE: begin
          if (sp_q >= SW'(STACK_DEPTH)) ex_err = ERR_STACK_RANGE;
          else begin
            w1_en   = 1'b1;
            w1_data = (op_e'(cmd_q) == OP_CRCT) ? arg_q : rdv_q;
            nsp     = sp_q + SW'(1);
          end
        end
        OP_CRVL: begin
          if (sp_q >= SW'(STACK_DEPTH) || fa_q < 0 || fa_q >= DepthW) begin
            ex_err = ERR_STACK_RANGE;
          end else begin
            w1_en   = 1'b1;
            w1_data = a_q;
            nsp     = sp_q + SW'(1);
          end
        end
        OP_ARMZ: begin
          if (sp_q == '0 || fa_q < 0 || fa_q >= DepthW) ex_err = ERR_STACK_RANGE;
          else begin
            w1_en   = 1'b1;
            w1_addr = fa_q[AW-1:0];
            w1_data = a_q;
            nsp     = sp_m1;
          end
        end
        OP_INVR: begin
          if (sp_q == '0) ex_err = ERR_STACK_RANGE;
          else begin
            w1_en   = 1'b1;
            w1_addr = sp_m1[AW-1:0];
            w1_data = DataW'(a_q == '0);
          end
        end
        OP_SOMA, OP_SUBT, OP_MULT, OP_DIVI, OP_CONJ, OP_DISJ, OP_CMME, OP_CMMA,
        OP_CMEQ, OP_CDIF, OP_CMMEQ, OP_CMMAQ: begin
          if (sp_q < SW'(2)) ex_err = ERR_STACK_RANGE;
          else if (op_e'(cmd_q) == OP_DIVI && b_q == '0) ex_err = ERR_DIV_ZERO;
          else begin
            need_div = (op_e'(cmd_q) == OP_DIVI) && !divd_q;
            w1_en    = 1'b1;
            w1_addr  = sp_m2[AW-1:0];
            w1_data  = alu;
            nsp      = sp_m1;
          end
        end
        OP_DSVS: npc = PcW'(tgt_q);
        OP_DSVF: begin
          if (sp_q == '0) ex_err = ERR_STACK_RANGE;
          else begin
            nsp = sp_m1;
            if (a_q == '0) npc = PcW'(tgt_q);
          end
        end
        OP_CHPR, OP_CHPD: begin
          if (sp_q == '0) ex_err = ERR_STACK_RANGE;
          else begin
            nsp  = sp_m1;
            pval = a_q;
            if (op_e'(cmd_q) == OP_CHPR && a_w >= wide_t'(PrintLow)
                && a_w <= wide_t'(PrintHigh)) begin
              kind = PK_CHAR;
            end else begin
              kind = PK_NUM;
            end
          end
        end
        OP_PARA: ;
        OP_CHAM: begin
          if (sp_q > SW'(STACK_DEPTH - 2)) ex_err = ERR_STACK_RANGE;
          else begin
            w1_en   = 1'b1;
            w1_data = DataW'(fp_q);
            w2_en   = 1'b1;
            w2_addr = AW'(sp_q + SW'(1));
            w2_data = DataW'(pc_q + PcW'(1));
            nsp     = sp_q + SW'(2);
            nfp     = sp_q + SW'(2);
            npc     = PcW'(tgt_q);
          end
        end
        OP_RETOR: begin
          // Return with an empty stack ends the program.
          if (sp_q == '0) npc = len;
          else if (fp_q < SW'(2)) ex_err = ERR_STACK_RANGE;
          else if (b_w < 0 || b_w > DepthW) ex_err = ERR_STACK_RANGE;
          else begin
            nsp = fp_m2;
            nfp = b_q[SW-1:0];
            npc = (a_w < 0 || a_w > CodeW) ? len : PcW'(a_q);
          end
        end
        OP_CRVI: begin
          if (sp_q == '0 || a_w < 0 || a_w >= DepthW) ex_err = ERR_STACK_RANGE;
          else begin
            w1_en   = 1'b1;
            w1_addr = sp_m1[AW-1:0];
            w1_data = b_q;
          end
        end
        OP_ARMI: begin
          if (sp_q < SW'(2) || a_w < 0 || a_w >= DepthW) ex_err = ERR_STACK_RANGE;
          else begin
            w1_en   = 1'b1;
            w1_addr = a_q[AW-1:0];
            w1_data = b_q;
            nsp     = sp_m2;
          end
        end
        OP_TROCA: begin
          if (sp_q < SW'(2)) ex_err = ERR_STACK_RANGE;
          else begin
            w1_en   = 1'b1;
            w1_addr = sp_m2[AW-1:0];
            w1_data = b_q;
            w2_en   = 1'b1;
            w2_addr = sp_m1[AW-1:0];
            w2_data = a_q;
          end
        end
        default: ex_err = ERR_UNKNOWN_OP;
      endcase
    end
    // A faulting instruction leaves the stack untouched and prints nothing.
    if (ex_err != ERR_NONE) begin
      w1_en    = 1'b0;
      w2_en    = 1'b0;
      need_div = 1'b0;
      kind     = PK_NONE;
      pval     = '0;
    end
  end

  assign ex_go     = (state_q == S_EXE) && !need_div && (!out_valid_q || out_ready_i);
  assign div_start = (state_q == S_EXE) && need_div;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w1_addr;
    ram_wdata = w1_data;
    priority if (state_q == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_WR2) begin
      ram_we    = 1'b1;
      ram_waddr = w2_addr_q;
      ram_wdata = w2_data_q;
    end else if (ex_go) begin
      ram_we = w1_en;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (clr_q == AW'(STACK_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_DEC;
      S_DEC:   state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_EXE;
      S_EXE: begin
        if (need_div) state_d = S_DIV;
        else if (ex_go) state_d = w2_en ? S_WR2 : S_IDLE;
      end
      S_DIV:   if (div_done) state_d = S_EXE;
      S_WR2:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      sp_q        <= '0;
      fp_q        <= '0;
      pc_q        <= '0;
      stopped_q   <= 1'b0;
      fault_q     <= ERR_NONE;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
      divd_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + AW'(1);
      if (cfg_valid_i && cfg_ready_o) plen_q <= cfg_data_i;
      if (accept) divd_q <= 1'b0;
      else if (state_q == S_DIV && div_done) divd_q <= 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (ex_go) begin
        out_valid_q <= 1'b1;
        if (halt_resp) begin
          stopped_q <= 1'b1;
        end else if (ex_err != ERR_NONE) begin
          stopped_q <= 1'b1;
          fault_q   <= ex_err;
        end else begin
          sp_q      <= nsp;
          fp_q      <= nfp;
          pc_q      <= npc;
          stopped_q <= (npc >= len);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      arg_q <= argument_i;
      tgt_q <= branch_target_i;
      rdv_q <= read_value_i;
    end
    if (state_q == S_DEC) begin
      fa_q  <= fa_d;
      adj_q <= adj_d;
    end
    if (state_q == S_RD1) a_q <= ram_rdata;
    if (state_q == S_RD2) b_q <= ram_rdata;
    if (ex_go) begin
      w2_addr_q <= w2_addr;
      w2_data_q <= w2_data;
      if (halt_resp) begin
        opc_q   <= pc_q[LenW-1:0];
        okind_q <= PK_NONE;
        opval_q <= '0;
        ohalt_q <= 1'b1;
        oerr_q  <= fault_q;
      end else if (ex_err != ERR_NONE) begin
        opc_q   <= pc_q[LenW-1:0];
        okind_q <= PK_NONE;
        opval_q <= '0;
        ohalt_q <= 1'b1;
        oerr_q  <= ex_err;
      end else begin
        opc_q   <= npc[LenW-1:0];
        okind_q <= kind;
        opval_q <= pval;
        ohalt_q <= (npc >= len);
        oerr_q  <= ERR_NONE;
      end
    end
  end

  smeu_ram #(
    .Width (DataW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  smeu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = opc_q;
  assign print_kind_o  = okind_q;
  assign print_value_o = opval_q;
  assign halted_o      = ohalt_q;
  assign error_code_o  = oerr_q;

  // An input transfer always starts the decode cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DEC))
    else $error("transfer did not start decode");

  // A new result only appears after an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EXE))
    else $error("result raised outside execute");

  // The stack top and the frame base stay within the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q <= SW'(STACK_DEPTH)) && (fp_q <= SW'(STACK_DEPTH)))
    else $error("stack pointer out of range");

  // Once halted, the stack pointers never move again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> (stopped_q && $stable(sp_q) && $stable(fp_q) && $stable(pc_q)))
    else $error("state changed after halt");

endmodule
